[rtl/dwts_pkg.sv]
package dwts_pkg;

  localparam int DW    = 32;          // result word
  localparam int FB    = 16;          // fraction bits
  localparam int HW    = 20;          // heading width
  localparam int DTW   = 31;          // time step / wheelbase width
  localparam int ANG_SH = 30 - FB;    // heading to Q30
  localparam int AW    = 36;          // Q30 angle accumulator
  localparam int CW    = 34;          // CORDIC x/y and multiplier operands
  localparam int PW    = 2 * CW;      // product
  localparam int NUMW  = 36;          // divider numerator (signed)
  localparam int NW    = NUMW + FB;   // scaled numerator magnitude
  localparam int QW    = 33;          // quotient bits developed
  localparam int SQW   = 64;          // square root working width

  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS   = 32;

  localparam logic signed [AW-1:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [AW-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [AW-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [PW-1:0] RND_HALF    = 68'sd536870912;

  localparam logic signed [DW-1:0] W_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] W_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [QW-1:0]        Q_LIM = QW'(1) << (DW - 1);

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE   = 5'd0;
  localparam op_t OP_LOAD   = 5'd1;
  localparam op_t OP_AMOD   = 5'd2;
  localparam op_t OP_AWRAP  = 5'd3;
  localparam op_t OP_AFOLD  = 5'd4;
  localparam op_t OP_CORD   = 5'd5;
  localparam op_t OP_SCFIX  = 5'd6;
  localparam op_t OP_MULS   = 5'd7;
  localparam op_t OP_MULC   = 5'd8;
  localparam op_t OP_OFS    = 5'd9;
  localparam op_t OP_PT     = 5'd10;
  localparam op_t OP_MAG    = 5'd11;
  localparam op_t OP_SQX    = 5'd12;
  localparam op_t OP_SQY    = 5'd13;
  localparam op_t OP_SQSUM  = 5'd14;
  localparam op_t OP_SQRT   = 5'd15;
  localparam op_t OP_DIST   = 5'd16;
  localparam op_t OP_DSTART = 5'd17;
  localparam op_t OP_DSTEP  = 5'd18;
  localparam op_t OP_DEND   = 5'd19;
  localparam op_t OP_EMIT   = 5'd20;

  typedef logic [1:0] dsel_t;

  localparam dsel_t DSEL_VEL  = 2'd0;
  localparam dsel_t DSEL_ACC  = 2'd1;
  localparam dsel_t DSEL_JERK = 2'd2;

  typedef struct packed {
    op_t        op;
    logic       side;
    logic [5:0] cnt;
    dsel_t      dsel;
  } cmd_t;

  function automatic logic signed [AW-1:0] atan_q30(input logic [4:0] i);
    logic signed [AW-1:0] v;
    case (i)
      5'd0:  v = 36'sd843314857;
      5'd1:  v = 36'sd497837829;
      5'd2:  v = 36'sd263043837;
      5'd3:  v = 36'sd133525159;
      5'd4:  v = 36'sd67021687;
      5'd5:  v = 36'sd33543516;
      5'd6:  v = 36'sd16775851;
      5'd7:  v = 36'sd8388437;
      5'd8:  v = 36'sd4194283;
      5'd9:  v = 36'sd2097149;
      default: v = AW'(36'sd1 <<< (30 - i));
    endcase
    return v;
  endfunction

  function automatic logic signed [DW-1:0] sat_w(input logic signed [39:0] v);
    logic signed [DW-1:0] r;
    if (v[39:DW-1] != {(41-DW){v[39]}}) begin
      r = v[39] ? W_MIN : W_MAX;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/dwts_ctrl.sv]
module dwts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  logic          first_seg,
  output dwts_pkg::cmd_t cmd
);
  import dwts_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_AMOD   = 5'd1;
  localparam logic [4:0] S_AWRAP  = 5'd2;
  localparam logic [4:0] S_AFOLD  = 5'd3;
  localparam logic [4:0] S_CORD   = 5'd4;
  localparam logic [4:0] S_SCFIX  = 5'd5;
  localparam logic [4:0] S_MULS   = 5'd6;
  localparam logic [4:0] S_MULC   = 5'd7;
  localparam logic [4:0] S_OFS    = 5'd8;
  localparam logic [4:0] S_PT     = 5'd9;
  localparam logic [4:0] S_MAG    = 5'd10;
  localparam logic [4:0] S_SQX    = 5'd11;
  localparam logic [4:0] S_SQY    = 5'd12;
  localparam logic [4:0] S_SQSUM  = 5'd13;
  localparam logic [4:0] S_SQRT   = 5'd14;
  localparam logic [4:0] S_DIST   = 5'd15;
  localparam logic [4:0] S_DSTART = 5'd16;
  localparam logic [4:0] S_DSTEP  = 5'd17;
  localparam logic [4:0] S_DEND   = 5'd18;
  localparam logic [4:0] S_EMIT   = 5'd19;

  logic [4:0] state_r, state_nxt;
  logic       side_r, side_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  dsel_t      dsel_r, dsel_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    side_nxt      = side_r;
    cnt_nxt       = cnt_r;
    dsel_nxt      = dsel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    cmd.side      = side_r;
    cmd.cnt       = cnt_r;
    cmd.dsel      = dsel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          side_nxt  = 1'b0;
          state_nxt = S_AMOD;
        end
      end
      S_AMOD: begin
        cmd.op    = OP_AMOD;
        state_nxt = S_AWRAP;
      end
      S_AWRAP: begin
        cmd.op    = OP_AWRAP;
        state_nxt = S_AFOLD;
      end
      S_AFOLD: begin
        cmd.op    = OP_AFOLD;
        cnt_nxt   = '0;
        state_nxt = S_CORD;
      end
      S_CORD: begin
        cmd.op = OP_CORD;
        if (cnt_r == 6'(CORDIC_STEPS - 1)) begin
          state_nxt = S_SCFIX;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_SCFIX: begin
        cmd.op    = OP_SCFIX;
        state_nxt = S_MULS;
      end
      S_MULS: begin
        cmd.op    = OP_MULS;
        state_nxt = S_MULC;
      end
      S_MULC: begin
        cmd.op    = OP_MULC;
        state_nxt = S_OFS;
      end
      S_OFS: begin
        cmd.op    = OP_OFS;
        state_nxt = S_PT;
      end
      S_PT: begin
        cmd.op    = OP_PT;
        state_nxt = first_seg ? S_EMIT : S_MAG;
      end
      S_MAG: begin
        cmd.op    = OP_MAG;
        state_nxt = S_SQX;
      end
      S_SQX: begin
        cmd.op    = OP_SQX;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.op    = OP_SQY;
        state_nxt = S_SQSUM;
      end
      S_SQSUM: begin
        cmd.op    = OP_SQSUM;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (cnt_r == 6'(SQRT_STEPS - 1)) begin
          state_nxt = S_DIST;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_DIST: begin
        cmd.op    = OP_DIST;
        dsel_nxt  = DSEL_VEL;
        state_nxt = S_DSTART;
      end
      S_DSTART: begin
        cmd.op    = OP_DSTART;
        cnt_nxt   = '0;
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        cmd.op = OP_DSTEP;
        if (cnt_r == 6'(QW - 1)) begin
          state_nxt = S_DEND;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      S_DEND: begin
        cmd.op = OP_DEND;
        if (dsel_r == DSEL_JERK) begin
          state_nxt = S_EMIT;
        end else begin
          dsel_nxt  = dsel_r + 2'd1;
          state_nxt = S_DSTART;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (slot_free) begin
          cmd.op        = OP_EMIT;
          out_valid_nxt = 1'b1;
          if (side_r) begin
            state_nxt = S_IDLE;
          end else begin
            side_nxt  = 1'b1;
            state_nxt = S_PT;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      side_r      <= 1'b0;
      cnt_r       <= '0;
      dsel_r      <= DSEL_VEL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      side_r      <= side_nxt;
      cnt_r       <= cnt_nxt;
      dsel_r      <= dsel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/dwts_dp.sv]
module dwts_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dwts_pkg::cmd_t                        cmd,
  output logic                                  first_seg,
  input  logic                                  cfg_we,
  input  logic [dwts_pkg::DTW-1:0]              cfg_wheelbase_width,
  input  logic                                  in_first_segment,
  input  logic signed [dwts_pkg::DW-1:0]        in_center_x,
  input  logic signed [dwts_pkg::DW-1:0]        in_center_y,
  input  logic signed [dwts_pkg::HW-1:0]        in_heading,
  input  logic [dwts_pkg::DTW-1:0]              in_time_step,
  input  logic signed [dwts_pkg::DW-1:0]        in_center_position,
  input  logic signed [dwts_pkg::DW-1:0]        in_center_velocity,
  input  logic signed [dwts_pkg::DW-1:0]        in_center_acceleration,
  input  logic signed [dwts_pkg::DW-1:0]        in_center_jerk,
  output logic                                  out_side,
  output logic signed [dwts_pkg::DW-1:0]        out_wheel_x,
  output logic signed [dwts_pkg::DW-1:0]        out_wheel_y,
  output logic signed [dwts_pkg::DW-1:0]        out_wheel_position,
  output logic signed [dwts_pkg::DW-1:0]        out_wheel_velocity,
  output logic signed [dwts_pkg::DW-1:0]        out_wheel_acceleration,
  output logic signed [dwts_pkg::DW-1:0]        out_wheel_jerk,
  output logic                                  out_last_of_pair
);
  import dwts_pkg::*;

  logic [DTW-1:0]        wb_r;
  logic                  first_r;
  logic signed [DW-1:0]  cen_x_r, cen_y_r;
  logic signed [DW-1:0]  pos_in_r, vel_in_r, acc_in_r, jerk_in_r;
  logic [DTW-1:0]        dt_r;
  logic signed [AW-1:0]  ang_r;
  logic                  neg_r;
  logic signed [CW-1:0]  crx_r, cry_r;
  logic signed [PW-1:0]  prod_r;
  logic signed [DW-1:0]  ps_r, pc_r;
  logic signed [DW-1:0]  wx_r, wy_r;
  logic [DW-2:0]         ax_r, ay_r;
  logic                  sh_r;
  logic [SQW-1:0]        sqv_r, sres_r;
  logic [DW:0]           dist_r;
  logic signed [DW-1:0]  pos_r, vel_r, acc_r, jerk_r;
  logic                  dneg_r, dnz_r, dovf_r;
  logic [DTW-1:0]        drem_r;
  logic [QW-1:0]         dquo_r, dlo_r;
  logic signed [DW-1:0]  prev_x_r   [2];
  logic signed [DW-1:0]  prev_y_r   [2];
  logic signed [DW-1:0]  prev_pos_r [2];
  logic signed [DW-1:0]  prev_vel_r [2];
  logic signed [DW-1:0]  prev_acc_r [2];
  logic                  o_side_r;
  logic signed [DW-1:0]  o_x_r, o_y_r, o_pos_r, o_vel_r, o_acc_r, o_jerk_r;

  logic                  k;
  logic signed [AW-1:0]  ang_load, at;
  logic signed [CW-1:0]  xsh, ysh, ma, mb;
  logic signed [PW-1:0]  mul_p, rnd_t;
  logic signed [DW:0]    px, py, dx, dy;
  logic [DW-1:0]         mx, my;
  logic                  sh_n;
  logic [SQW-1:0]        sbit, st;
  logic [6:0]            samt;
  logic [DW:0]           dist_n;
  logic signed [NUMW-1:0] num;
  logic [NUMW-1:0]       dmag;
  logic [NW-1:0]         dn;
  logic [DW-1:0]         r2, rdiff;
  logic                  rge;
  logic signed [DW-1:0]  dres;

  assign first_seg = first_r;
  assign k         = cmd.side;

  assign ang_load = {{(AW-HW-ANG_SH){in_heading[HW-1]}}, in_heading, {ANG_SH{1'b0}}};
  assign at       = atan_q30(cmd.cnt[4:0]);
  assign xsh      = crx_r >>> cmd.cnt[4:0];
  assign ysh      = cry_r >>> cmd.cnt[4:0];

  // shared multiplier: offset products and squares
  always_comb begin
    case (cmd.op)
      OP_MULS: begin
        ma = $signed({{(CW-DTW+1){1'b0}}, wb_r[DTW-1:1]});
        mb = cry_r;
      end
      OP_MULC: begin
        ma = $signed({{(CW-DTW+1){1'b0}}, wb_r[DTW-1:1]});
        mb = crx_r;
      end
      OP_SQY: begin
        ma = $signed({{(CW-DW+1){1'b0}}, ay_r});
        mb = ma;
      end
      default: begin
        ma = $signed({{(CW-DW+1){1'b0}}, ax_r});
        mb = ma;
      end
    endcase
  end
  assign mul_p = ma * mb;
  assign rnd_t = prod_r + RND_HALF;

  assign px = k ? ({cen_x_r[DW-1], cen_x_r} + {ps_r[DW-1], ps_r})
                : ({cen_x_r[DW-1], cen_x_r} - {ps_r[DW-1], ps_r});
  assign py = k ? ({cen_y_r[DW-1], cen_y_r} - {pc_r[DW-1], pc_r})
                : ({cen_y_r[DW-1], cen_y_r} + {pc_r[DW-1], pc_r});

  assign dx   = {wx_r[DW-1], wx_r} - {prev_x_r[k][DW-1], prev_x_r[k]};
  assign dy   = {wy_r[DW-1], wy_r} - {prev_y_r[k][DW-1], prev_y_r[k]};
  assign mx   = dx[DW] ? DW'(-dx) : dx[DW-1:0];
  assign my   = dy[DW] ? DW'(-dy) : dy[DW-1:0];
  assign sh_n = mx[DW-1] | my[DW-1];

  assign samt = 7'd62 - {1'b0, cmd.cnt[4:0], 1'b0};
  assign sbit = SQW'(1) << samt;
  assign st   = sres_r + sbit;

  assign dist_n = sh_r ? {sres_r[DW-1:0], 1'b0} : {1'b0, sres_r[DW-1:0]};

  always_comb begin
    case (cmd.dsel)
      DSEL_VEL: num = {{(NUMW-DW-1){1'b0}}, dist_r};
      DSEL_ACC: num = {{(NUMW-DW){vel_r[DW-1]}}, vel_r}
                    - {{(NUMW-DW){prev_vel_r[k][DW-1]}}, prev_vel_r[k]};
      DSEL_JERK: num = {{(NUMW-DW){acc_r[DW-1]}}, acc_r}
                     - {{(NUMW-DW){prev_acc_r[k][DW-1]}}, prev_acc_r[k]};
      default: num = '0;
    endcase
  end
  assign dmag = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
  assign dn   = {dmag, {FB{1'b0}}};

  assign r2    = {drem_r, dlo_r[QW-1]};
  assign rdiff = r2 - {1'b0, dt_r};
  assign rge   = (r2 >= {1'b0, dt_r});

  always_comb begin
    if (dt_r == '0) begin
      dres = dnz_r ? (dneg_r ? W_MIN : W_MAX) : '0;
    end else if (dovf_r) begin
      dres = dneg_r ? W_MIN : W_MAX;
    end else if (dneg_r) begin
      dres = (dquo_r > Q_LIM) ? W_MIN : $signed(~dquo_r[DW-1:0] + DW'(1));
    end else begin
      dres = (dquo_r >= Q_LIM) ? W_MAX : $signed(dquo_r[DW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r <= '0;
    end else if (cfg_we) begin
      wb_r <= cfg_wheelbase_width;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        first_r   <= in_first_segment;
        cen_x_r   <= in_center_x;
        cen_y_r   <= in_center_y;
        dt_r      <= in_time_step;
        pos_in_r  <= in_center_position;
        vel_in_r  <= in_center_velocity;
        acc_in_r  <= in_center_acceleration;
        jerk_in_r <= in_center_jerk;
        ang_r     <= ang_load;
      end
      OP_AMOD: begin
        if (ang_r >= Q30_TWO_PI) begin
          ang_r <= ang_r - Q30_TWO_PI;
        end else if (ang_r <= -Q30_TWO_PI) begin
          ang_r <= ang_r + Q30_TWO_PI;
        end
      end
      OP_AWRAP: begin
        if (ang_r > Q30_PI) begin
          ang_r <= ang_r - Q30_TWO_PI;
        end else if (ang_r < -Q30_PI) begin
          ang_r <= ang_r + Q30_TWO_PI;
        end
      end
      OP_AFOLD: begin
        // fold to the right half plane, negate at the end
        if (ang_r > Q30_HALF_PI) begin
          ang_r <= ang_r - Q30_PI;
          neg_r <= 1'b1;
        end else if (ang_r < -Q30_HALF_PI) begin
          ang_r <= ang_r + Q30_PI;
          neg_r <= 1'b1;
        end else begin
          neg_r <= 1'b0;
        end
        crx_r <= CORDIC_GAIN;
        cry_r <= '0;
      end
      OP_CORD: begin
        if (!ang_r[AW-1]) begin
          crx_r <= crx_r - ysh;
          cry_r <= cry_r + xsh;
          ang_r <= ang_r - at;
        end else begin
          crx_r <= crx_r + ysh;
          cry_r <= cry_r - xsh;
          ang_r <= ang_r + at;
        end
      end
      OP_SCFIX: begin
        if (neg_r) begin
          crx_r <= -crx_r;
          cry_r <= -cry_r;
        end
      end
      OP_MULS: prod_r <= mul_p;
      OP_MULC: begin
        ps_r   <= rnd_t[DW+29:30];
        prod_r <= mul_p;
      end
      OP_OFS: pc_r <= rnd_t[DW+29:30];
      OP_PT: begin
        wx_r <= sat_w({{(40-DW-1){px[DW]}}, px});
        wy_r <= sat_w({{(40-DW-1){py[DW]}}, py});
      end
      OP_MAG: begin
        sh_r <= sh_n;
        ax_r <= sh_n ? mx[DW-1:1] : mx[DW-2:0];
        ay_r <= sh_n ? my[DW-1:1] : my[DW-2:0];
      end
      OP_SQX: prod_r <= mul_p;
      OP_SQY: begin
        sqv_r  <= SQW'(prod_r[SQW-2:0]);
        prod_r <= mul_p;
      end
      OP_SQSUM: begin
        sqv_r  <= sqv_r + SQW'(prod_r[SQW-2:0]);
        sres_r <= '0;
      end
      OP_SQRT: begin
        if (sqv_r >= st) begin
          sqv_r  <= sqv_r - st;
          sres_r <= (sres_r >> 1) + sbit;
        end else begin
          sres_r <= sres_r >> 1;
        end
      end
      OP_DIST: begin
        dist_r <= dist_n;
        pos_r  <= sat_w({{(40-DW){prev_pos_r[k][DW-1]}}, prev_pos_r[k]}
                        + {{(40-DW-1){1'b0}}, dist_n});
      end
      OP_DSTART: begin
        dneg_r <= num[NUMW-1];
        dnz_r  <= (num != '0);
        dovf_r <= ({{(DTW-(NW-QW)){1'b0}}, dn[NW-1:QW]} >= dt_r);
        drem_r <= {{(DTW-(NW-QW)){1'b0}}, dn[NW-1:QW]};
        dlo_r  <= dn[QW-1:0];
        dquo_r <= '0;
      end
      OP_DSTEP: begin
        drem_r <= rge ? rdiff[DTW-1:0] : r2[DTW-1:0];
        dquo_r <= {dquo_r[QW-2:0], rge};
        dlo_r  <= {dlo_r[QW-2:0], 1'b0};
      end
      OP_DEND: begin
        case (cmd.dsel)
          DSEL_VEL: vel_r <= dres;
          DSEL_ACC: acc_r <= dres;
          default:  jerk_r <= dres;
        endcase
      end
      OP_EMIT: begin
        o_side_r <= k;
        o_x_r    <= wx_r;
        o_y_r    <= wy_r;
        o_pos_r  <= first_r ? pos_in_r  : pos_r;
        o_vel_r  <= first_r ? vel_in_r  : vel_r;
        o_acc_r  <= first_r ? acc_in_r  : acc_r;
        o_jerk_r <= first_r ? jerk_in_r : jerk_r;
      end
      default: ;
    endcase
  end

  // per-wheel history, written as each result is handed off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        prev_x_r[i]   <= '0;
        prev_y_r[i]   <= '0;
        prev_pos_r[i] <= '0;
        prev_vel_r[i] <= '0;
        prev_acc_r[i] <= '0;
      end
    end else if (cmd.op == OP_EMIT) begin
      prev_x_r[k]   <= wx_r;
      prev_y_r[k]   <= wy_r;
      prev_pos_r[k] <= first_r ? pos_in_r : pos_r;
      prev_vel_r[k] <= first_r ? vel_in_r : vel_r;
      prev_acc_r[k] <= first_r ? acc_in_r : acc_r;
    end
  end

  assign out_side               = o_side_r;
  assign out_wheel_x            = o_x_r;
  assign out_wheel_y            = o_y_r;
  assign out_wheel_position     = o_pos_r;
  assign out_wheel_velocity     = o_vel_r;
  assign out_wheel_acceleration = o_acc_r;
  assign out_wheel_jerk         = o_jerk_r;
  assign out_last_of_pair       = o_side_r;

endmodule

[rtl/differential_wheel_trajectory_split.sv]
// Differential-drive trajectory split.
// Input channel (in_valid/in_ready): one centre-path segment per transfer.
// Output channel (out_valid/out_ready): two results per segment, left wheel
// (out_side 0) then right wheel (out_side 1, out_last_of_pair 1).
// Config channel (cfg_valid/cfg_ready): full wheelbase width, always ready;
// write it only while the block is idle.
// Every segment runs a 30-step CORDIC shared by both wheels. For any
// segment but a first one, each wheel then needs a 32-step square root
// and three 33-step divisions sharing one restoring divider. One segment
// is in work at a time; in_ready is high only when the sequencer is idle.
// A finished result sits in the output register; while the receiver stalls
// the block keeps computing and waits only when the next result is ready.
// Reset clears the wheelbase width and both wheels' history to zero and
// drops any result not yet transferred.
module differential_wheel_trajectory_split (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dwts_pkg::DTW-1:0]       cfg_wheelbase_width,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_first_segment,
  input  logic signed [dwts_pkg::DW-1:0] in_center_x,
  input  logic signed [dwts_pkg::DW-1:0] in_center_y,
  input  logic signed [dwts_pkg::HW-1:0] in_heading,
  input  logic [dwts_pkg::DTW-1:0]       in_time_step,
  input  logic signed [dwts_pkg::DW-1:0] in_center_position,
  input  logic signed [dwts_pkg::DW-1:0] in_center_velocity,
  input  logic signed [dwts_pkg::DW-1:0] in_center_acceleration,
  input  logic signed [dwts_pkg::DW-1:0] in_center_jerk,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_side,
  output logic signed [dwts_pkg::DW-1:0] out_wheel_x,
  output logic signed [dwts_pkg::DW-1:0] out_wheel_y,
  output logic signed [dwts_pkg::DW-1:0] out_wheel_position,
  output logic signed [dwts_pkg::DW-1:0] out_wheel_velocity,
  output logic signed [dwts_pkg::DW-1:0] out_wheel_acceleration,
  output logic signed [dwts_pkg::DW-1:0] out_wheel_jerk,
  output logic                           out_last_of_pair
);
  import dwts_pkg::*;

  cmd_t cmd;
  logic first_seg;

  assign cfg_ready = 1'b1;

  dwts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .first_seg (first_seg),
    .cmd       (cmd)
  );

  dwts_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .first_seg              (first_seg),
    .cfg_we                 (cfg_valid && cfg_ready),
    .cfg_wheelbase_width    (cfg_wheelbase_width),
    .in_first_segment       (in_first_segment),
    .in_center_x            (in_center_x),
    .in_center_y            (in_center_y),
    .in_heading             (in_heading),
    .in_time_step           (in_time_step),
    .in_center_position     (in_center_position),
    .in_center_velocity     (in_center_velocity),
    .in_center_acceleration (in_center_acceleration),
    .in_center_jerk         (in_center_jerk),
    .out_side               (out_side),
    .out_wheel_x            (out_wheel_x),
    .out_wheel_y            (out_wheel_y),
    .out_wheel_position     (out_wheel_position),
    .out_wheel_velocity     (out_wheel_velocity),
    .out_wheel_acceleration (out_wheel_acceleration),
    .out_wheel_jerk         (out_wheel_jerk),
    .out_last_of_pair       (out_last_of_pair)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a segment is in work");

  a_last_matches_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_of_pair == out_side))
    else $error("last_of_pair and side disagree");

  a_left_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_side) |-> !in_ready)
    else $error("left result pending while sequencer idle");

endmodule
